>>> hdl/assert_macros.svh
// Assertion macros for the checker of the video register block.
// Each macro expects aclk and aresetn to be visible in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VRTC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/vrtc_pkg.sv
// Package for the video register and timing core: payload structs, command,
// register and access codes, and frame timing constants. No dependencies.
`default_nettype none

package vrtc_pkg;

    localparam int DOTS_PER_LINE   = 341;
    localparam int LINES_PER_FRAME = 262;
    localparam int VISIBLE_DOTS    = 256;
    localparam int VISIBLE_LINES   = 240;

    localparam int COUNT_W    = 9;
    localparam int OAM_DEPTH  = 256;
    localparam int OAM_AW     = 8;

    localparam int CTRL_STEP_BIT  = 2;
    localparam int CTRL_IRQ_BIT   = 7;
    localparam int MASK_SPCLR_BIT = 4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_e;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SPIDX  = 3'd3;
    localparam logic [2:0] REG_SPDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] vram_read_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  vram_access;
        logic [15:0] vram_address;
        logic [7:0]  vram_write_data;
        logic        irq;
        logic        in_vblank;
    } out_item_t;

    // Events decoded from the dot and line counters before a tick applies.
    typedef struct packed {
        logic frame_start;
        logic vblank_set;
        logic sprite_window;
    } timing_evt_t;

endpackage

`default_nettype wire

>>> hdl/video_register_timing_core.sv
// Video register and timing core, top level.
// Channels: s_ (valid/ready) carries one transaction per command: a dot tick,
// a CPU register write or a CPU register read; m_ (valid/ready) returns one
// result per transaction with read data, the video memory request made by a
// data-port access, and the irq and vblank lines after the command.
// A result is registered and appears in the cycle after its acceptance.
// Throughput: one transaction per cycle unless m_ stalls; all state updates
// and the result are computed in one pass from the incoming payload and the
// state registers. The sprite memory read port is registered and always
// addresses the index left by the previous transaction, so no read waits.
// Stall: s_ready is high whenever the result register is empty or being
// taken, so a stalled receiver holds the result and stops new input.
// Reset (aresetn low, synchronous): control and state registers, result valid,
// counters, sprite index and sprite memory valid bits clear at once; the sprite
// memory reads as zero until written, and the block is ready in the next cycle.
// Depends on vrtc_pkg, vrtc_timing and vrtc_oam.
`default_nettype none

module video_register_timing_core
    import vrtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    logic [7:0]  ctrl_reg,   ctrl_next;
    logic [7:0]  mask_reg,   mask_next;
    logic        vblank_reg, vblank_next;
    logic        pend_reg,   pend_next;
    logic [15:0] vaddr_reg,  vaddr_next;
    logic [OAM_AW-1:0] spidx_reg, spidx_next;

    logic        m_valid_reg;
    out_item_t   m_data_reg, m_data_next;

    logic        s_fire;
    logic        tick_en;
    logic        oam_we;
    logic [7:0]  oam_rdata;
    logic [15:0] vaddr_step;
    timing_evt_t evt;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign tick_en = s_fire && (s_data.cmd == CMD_TICK);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    vrtc_timing u_timing (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (tick_en),
        .evt     (evt)
    );

    vrtc_oam u_oam (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (oam_we),
        .wr_addr (spidx_reg),
        .wr_data (s_data.write_data),
        .rd_addr (spidx_next),
        .rd_data (oam_rdata)
    );

    assign vaddr_step = ctrl_reg[CTRL_STEP_BIT] ? 16'd32 : 16'd1;

    always_comb begin
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        vblank_next = vblank_reg;
        pend_next   = pend_reg;
        vaddr_next  = vaddr_reg;
        spidx_next  = spidx_reg;
        oam_we      = 1'b0;
        m_data_next = '0;

        if (s_fire) begin
            case (s_data.cmd)
                CMD_TICK: begin
                    if (evt.frame_start) begin
                        vblank_next = 1'b0;
                        pend_next   = 1'b0;
                    end
                    if (evt.vblank_set) begin
                        vblank_next = 1'b1;
                        pend_next   = 1'b1;
                    end
                    if (evt.sprite_window && mask_reg[MASK_SPCLR_BIT]) begin
                        spidx_next = '0;
                    end
                end
                CMD_WRITE: begin
                    case (s_data.reg_addr)
                        REG_CTRL:   ctrl_next = s_data.write_data;
                        REG_MASK:   mask_next = s_data.write_data;
                        REG_SPIDX:  spidx_next = s_data.write_data;
                        REG_SPDATA: begin
                            oam_we     = 1'b1;
                            spidx_next = spidx_reg + OAM_AW'(1);
                        end
                        REG_ADDR:   vaddr_next = {2'b00, vaddr_reg[5:0], s_data.write_data};
                        REG_DATA: begin
                            m_data_next.vram_access     = ACC_WRITE;
                            m_data_next.vram_address    = vaddr_reg;
                            m_data_next.vram_write_data = s_data.write_data;
                            vaddr_next                  = vaddr_reg + vaddr_step;
                        end
                        default: ;
                    endcase
                end
                CMD_READ: begin
                    case (s_data.reg_addr)
                        REG_CTRL:   m_data_next.read_data = ctrl_reg;
                        REG_MASK:   m_data_next.read_data = mask_reg;
                        REG_STATUS: begin
                            m_data_next.read_data = {vblank_reg, 7'b0};
                            vblank_next           = 1'b0;
                        end
                        REG_SPDATA: m_data_next.read_data = oam_rdata;
                        REG_ADDR:   m_data_next.read_data = vaddr_reg[7:0];
                        REG_DATA: begin
                            m_data_next.vram_access  = ACC_READ;
                            m_data_next.vram_address = vaddr_reg;
                            m_data_next.read_data    = s_data.vram_read_data;
                            vaddr_next               = vaddr_reg + vaddr_step;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        m_data_next.irq       = ctrl_next[CTRL_IRQ_BIT] && pend_next;
        m_data_next.in_vblank = vblank_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '0;
            mask_reg    <= '0;
            vblank_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            vaddr_reg   <= '0;
            spidx_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ctrl_reg   <= ctrl_next;
            mask_reg   <= mask_next;
            vblank_reg <= vblank_next;
            pend_reg   <= pend_next;
            vaddr_reg  <= vaddr_next;
            spidx_reg  <= spidx_next;
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/vrtc_timing.sv
// Dot and line counters with frame event decode.
// Depends on vrtc_pkg.
`default_nettype none

module vrtc_timing
    import vrtc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        tick_en,
    output timing_evt_t      evt
);

    logic [COUNT_W-1:0] dot_reg,  dot_next;
    logic [COUNT_W-1:0] line_reg, line_next;
    logic [COUNT_W-1:0] dot_inc,  line_inc;

    assign evt.frame_start   = (dot_reg == '0) && (line_reg == '0);
    assign evt.vblank_set    = (dot_reg == COUNT_W'(1))
                             && (line_reg == COUNT_W'(VISIBLE_LINES + 1));
    assign evt.sprite_window = (line_reg < COUNT_W'(VISIBLE_LINES))
                             && (dot_reg >= COUNT_W'(VISIBLE_DOTS));

    always_comb begin
        dot_inc   = dot_reg + COUNT_W'(1);
        line_inc  = line_reg + COUNT_W'(1);
        dot_next  = dot_reg;
        line_next = line_reg;
        if (tick_en) begin
            dot_next = dot_inc;
            if (dot_inc >= COUNT_W'(DOTS_PER_LINE)) begin
                dot_next  = '0;
                line_next = line_inc;
                if (line_inc >= COUNT_W'(LINES_PER_FRAME)) begin
                    line_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg  <= '0;
            line_reg <= '0;
        end else begin
            dot_reg  <= dot_next;
            line_reg <= line_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/vrtc_oam.sv
// Sprite attribute memory, 256 bytes, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Depends on vrtc_pkg.
`default_nettype none

module vrtc_oam
    import vrtc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [OAM_AW-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [OAM_AW-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0]           mem [OAM_DEPTH];
    logic [OAM_DEPTH-1:0] valid_reg;
    logic [7:0]           rdq_reg;
    logic                 rdv_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // forward a same-cycle write so the read is never stale
        if (wr_en && (wr_addr == rd_addr)) begin
            rdq_reg <= wr_data;
        end else begin
            rdq_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rdv_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rdv_reg <= valid_reg[rd_addr] || (wr_en && (wr_addr == rd_addr));
        end
    end

    assign rd_data = rdv_reg ? rdq_reg : 8'h00;

endmodule

`default_nettype wire

>>> hdl/vrtc_checker.sv
// Port-level checker for video_register_timing_core, attached by bind.
// Depends on vrtc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module vrtc_checker
    import vrtc_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // a stalled result must hold
    `VRTC_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // every accepted transaction yields a result in the next cycle
    `VRTC_ASSERT_NEXT(a_one_result, s_valid && s_ready, m_valid, "missing result after accepted transaction")

    // ticks and writes return no read data
    `VRTC_ASSERT_NEXT(a_no_rdata, s_valid && s_ready && (s_data.cmd != CMD_READ), m_data.read_data == 8'h00, "read data on non-read transaction")

    // idle request fields stay zero when no video access is made
    `VRTC_ASSERT(a_idle_fields, m_valid && (m_data.vram_access == ACC_NONE), (m_data.vram_address == 16'h0000) && (m_data.vram_write_data == 8'h00), "idle access fields not zero")

    // the receiver side is always free when the result register is empty
    `VRTC_ASSERT(a_ready_empty, !m_valid, s_ready, "not ready while result register empty")

endmodule

bind video_register_timing_core vrtc_checker u_vrtc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
